### hw/rtl/tbpus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpus_pkg
// shared types and constants of the tile byte plane unshuffle scatter block
// ----------------------------------------------------------------------------
package tbpus_pkg;

   localparam int CFG_DATA_W = 15;   // width of the dimension registers
   localparam int CSR_IDX_W  = 3;    // register index width
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 31;
   localparam int PLANE_W    = 3;    // up to eight byte planes
   localparam int SIZE_W     = 2;    // pixel size code

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_TILE_WIDTH   = 3'd2,
      CSR_TILE_HEIGHT  = 3'd3,
      CSR_PIXEL_SIZE   = 3'd4,
      CSR_REVERSE      = 3'd5
   } csr_index_type;

   // effective geometry after clamping, as seen by the address generator
   typedef struct packed {
      logic [CFG_DATA_W-1:0] image_width;
      logic [CFG_DATA_W-1:0] image_height;
      logic [CFG_DATA_W-1:0] tile_width;
      logic [CFG_DATA_W-1:0] tile_height;
      logic [SIZE_W-1:0]     size_code;
      logic                  reverse;
   } cfg_type;

   // address and markers for the item at the head of the stream
   typedef struct packed {
      logic [ADDR_W-1:0] byte_address;
      logic              tile_last;
      logic              image_last;
   } addr_info_type;

endpackage

### hw/rtl/tbpus_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpus channel interfaces
// byte input, address result and register write channels
// ----------------------------------------------------------------------------
interface tbpus_req_if
   import tbpus_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tbpus_rsp_if
   import tbpus_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] byte_address;
   logic [BYTE_W-1:0] write_byte;
   logic              tile_last;
   logic              image_last;

   modport source (output valid, output byte_address, output write_byte,
                   output tile_last, output image_last, input ready);
   modport sink   (input valid, input byte_address, input write_byte,
                   input tile_last, input image_last, output ready);
endinterface

interface tbpus_csr_if
   import tbpus_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CFG_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/tile_byte_plane_unshuffle_scatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_byte_plane_unshuffle_scatter
// scatters byte-shuffled tile data to byte addresses of a row-major image
// ----------------------------------------------------------------------------
// usage
//   req_chan: one decompressed byte per item, plane-major within each tile,
//     tiles in row-major order over the image
//   rsp_chan: one item per input byte with the image buffer byte address,
//     the byte itself, and tile_last / image_last markers
//   csr_chan: register writes (image width, image height, tile width,
//     tile height, pixel size code, byte order); always ready, and any
//     write to a listed register restarts the stream at the first tile
// timing
//   the result becomes valid in the cycle after input accept; one item per
//   cycle is sustained while rsp_chan is ready, set by the single result register
//   the counters and the line and tile base registers are updated
//   incrementally, so the address comes from a three-term add and a shift
// reset and stall
//   reset restores the register defaults and clears all counters
//   when rsp_chan stalls, the result register holds and req_chan.ready
//   drops only while that held result is still waiting
//   after the image_last item the stream wraps to the first tile
// ----------------------------------------------------------------------------
module tile_byte_plane_unshuffle_scatter
   import tbpus_pkg::*;
#(
   parameter int MAX_IMAGE_DIM = 16384
) (
   input  logic        clock,
   input  logic        reset,
   tbpus_req_if.sink   req_chan,
   tbpus_rsp_if.source rsp_chan,
   tbpus_csr_if.sink   csr_chan
);

   cfg_type       cfg;
   logic          clear;
   logic          step;
   addr_info_type info;

   // result register
   logic              rsp_valid_ff,   rsp_valid_in;
   addr_info_type     rsp_info_ff,    rsp_info_in;
   logic [BYTE_W-1:0] rsp_byte_ff,    rsp_byte_in;

   // register file, clamping and clear pulse on writes
   tbpus_cfg #(
      .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
   ) u_cfg (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg),
      .clear (clear)
   );

   // counters and address of the byte at the head of the stream
   tbpus_addr_gen #(
      .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
   ) u_addr_gen (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .clear (clear),
      .step  (step),
      .info  (info)
   );

   // take a new item whenever the result slot is empty or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_chan.valid && req_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_info_in  = rsp_info_ff;
      rsp_byte_in  = rsp_byte_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_info_in  = info;
         rsp_byte_in  = req_chan.data_byte;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_info_ff <= rsp_info_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.byte_address = rsp_info_ff.byte_address;
   assign rsp_chan.write_byte   = rsp_byte_ff;
   assign rsp_chan.tile_last    = rsp_info_ff.tile_last;
   assign rsp_chan.image_last   = rsp_info_ff.image_last;

endmodule

### hw/rtl/tbpus_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpus_cfg
// configuration registers, dimension clamping and counter clear on write
// ----------------------------------------------------------------------------
module tbpus_cfg
   import tbpus_pkg::*;
#(
   parameter int MAX_IMAGE_DIM = 16384
) (
   input  logic             clock,
   input  logic             reset,
   tbpus_csr_if.sink        csr,
   output cfg_type          cfg,
   output logic             clear
);

   localparam int          CMP_W   = CFG_DATA_W + 3;
   localparam [CMP_W-1:0]  MAX_DIM = CMP_W'(MAX_IMAGE_DIM);

   logic [CFG_DATA_W-1:0] image_width_ff,  image_width_in;
   logic [CFG_DATA_W-1:0] image_height_ff, image_height_in;
   logic [CFG_DATA_W-1:0] tile_width_ff,   tile_width_in;
   logic [CFG_DATA_W-1:0] tile_height_ff,  tile_height_in;
   logic [SIZE_W-1:0]     size_code_ff,    size_code_in;
   logic                  reverse_ff,      reverse_in;
   logic                  write_hit;
   logic [CFG_DATA_W-1:0] eff_w, eff_h, eff_tw, eff_th;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [CFG_DATA_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
      logic [CFG_DATA_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_DATA_W'(1);
      end else if (CMP_W'(v) > MAX_DIM) begin
         r = CFG_DATA_W'(MAX_DIM);
      end
      return r;
   endfunction

   assign csr.ready = 1'b1;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      tile_width_in   = tile_width_ff;
      tile_height_in  = tile_height_ff;
      size_code_in    = size_code_ff;
      reverse_in      = reverse_ff;
      write_hit       = 1'b0;
      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_IMAGE_WIDTH: begin
               image_width_in = csr.data;
               write_hit      = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = csr.data;
               write_hit       = 1'b1;
            end
            CSR_TILE_WIDTH: begin
               tile_width_in = csr.data;
               write_hit     = 1'b1;
            end
            CSR_TILE_HEIGHT: begin
               tile_height_in = csr.data;
               write_hit      = 1'b1;
            end
            CSR_PIXEL_SIZE: begin
               size_code_in = csr.data[SIZE_W-1:0];
               write_hit    = 1'b1;
            end
            CSR_REVERSE: begin
               reverse_in = csr.data[0];
               write_hit  = 1'b1;
            end
            default: begin
               write_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CFG_DATA_W'(1);
         image_height_ff <= CFG_DATA_W'(1);
         tile_width_ff   <= CFG_DATA_W'(1);
         tile_height_ff  <= CFG_DATA_W'(1);
         size_code_ff    <= '0;
         reverse_ff      <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         tile_width_ff   <= tile_width_in;
         tile_height_ff  <= tile_height_in;
         size_code_ff    <= size_code_in;
         reverse_ff      <= reverse_in;
      end
   end

   assign eff_w  = eff_dim(image_width_ff);
   assign eff_h  = eff_dim(image_height_ff);
   assign eff_tw = eff_dim(tile_width_ff);
   assign eff_th = eff_dim(tile_height_ff);

   // tiles larger than the image collapse to the image
   always_comb begin
      cfg.image_width  = eff_w;
      cfg.image_height = eff_h;
      cfg.tile_width   = (eff_tw > eff_w) ? eff_w : eff_tw;
      cfg.tile_height  = (eff_th > eff_h) ? eff_h : eff_th;
      cfg.size_code    = size_code_ff;
      cfg.reverse      = reverse_ff;
   end

   assign clear = write_hit;

endmodule

### hw/rtl/tbpus_addr_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpus_addr_gen
// plane, line and pixel counters with incremental tile and line bases
// ----------------------------------------------------------------------------
module tbpus_addr_gen
   import tbpus_pkg::*;
#(
   parameter int MAX_IMAGE_DIM = 16384
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          clear,
   input  logic          step,
   output addr_info_type info
);

   localparam int IDX_W = (MAX_IMAGE_DIM > 1) ? $clog2(MAX_IMAGE_DIM) : 1;
   localparam int PIX_W = 2 * IDX_W;
   localparam int CMP_W = ((IDX_W > CFG_DATA_W) ? IDX_W : CFG_DATA_W) + 2;
   localparam int SHF_W = PIX_W + 7;

   logic [PLANE_W-1:0] plane_ff,         plane_in;
   logic [IDX_W-1:0]   col_ff,           col_in;
   logic [IDX_W-1:0]   row_ff,           row_in;
   logic [IDX_W-1:0]   col_origin_ff,    col_origin_in;
   logic [IDX_W-1:0]   row_origin_ff,    row_origin_in;
   logic [PIX_W-1:0]   row_line_ff,      row_line_in;
   logic [PIX_W-1:0]   tile_row_base_ff, tile_row_base_in;

   logic [CMP_W-1:0]   w_x, h_x, tw_x, th_x;
   logic               col_done, row_done, plane_done;
   logic               tile_col_last, tile_row_last;
   logic [PLANE_W:0]   size_x;
   logic [PLANE_W-1:0] size_mask, place;
   logic [PIX_W-1:0]   pixel, next_line;
   logic [SHF_W-1:0]   shifted;

   assign w_x  = CMP_W'(cfg.image_width);
   assign h_x  = CMP_W'(cfg.image_height);
   assign tw_x = CMP_W'(cfg.tile_width);
   assign th_x = CMP_W'(cfg.tile_height);

   // end of line, end of plane within the clipped tile, end of pixel bytes
   assign col_done = (CMP_W'(col_ff) + CMP_W'(1) >= tw_x) ||
                     (CMP_W'(col_origin_ff) + CMP_W'(col_ff) + CMP_W'(1) >= w_x);
   assign row_done = (CMP_W'(row_ff) + CMP_W'(1) >= th_x) ||
                     (CMP_W'(row_origin_ff) + CMP_W'(row_ff) + CMP_W'(1) >= h_x);
   assign size_x     = (PLANE_W+1)'(1) << cfg.size_code;
   assign plane_done = ((PLANE_W+1)'(plane_ff) + (PLANE_W+1)'(1)) >= size_x;

   // last tile on an axis when the next origin would be past the image
   assign tile_col_last = (CMP_W'(col_origin_ff) + tw_x) >= w_x;
   assign tile_row_last = (CMP_W'(row_origin_ff) + th_x) >= h_x;

   assign size_mask = PLANE_W'(size_x - (PLANE_W+1)'(1));
   assign place     = (plane_ff & size_mask) ^ (cfg.reverse ? size_mask : '0);

   assign pixel   = row_line_ff + PIX_W'(col_origin_ff) + PIX_W'(col_ff);
   assign shifted = SHF_W'(pixel) << cfg.size_code;

   always_comb begin
      info.byte_address = ADDR_W'(shifted | SHF_W'(place));
      info.tile_last    = plane_done && row_done && col_done;
      info.image_last   = plane_done && row_done && col_done &&
                          tile_col_last && tile_row_last;
   end

   assign next_line = row_line_ff + PIX_W'(cfg.image_width);

   always_comb begin
      plane_in         = plane_ff;
      col_in           = col_ff;
      row_in           = row_ff;
      col_origin_in    = col_origin_ff;
      row_origin_in    = row_origin_ff;
      row_line_in      = row_line_ff;
      tile_row_base_in = tile_row_base_ff;
      if (clear) begin
         plane_in         = '0;
         col_in           = '0;
         row_in           = '0;
         col_origin_in    = '0;
         row_origin_in    = '0;
         row_line_in      = '0;
         tile_row_base_in = '0;
      end else if (step) begin
         if (!col_done) begin
            col_in = col_ff + IDX_W'(1);
         end else begin
            col_in = '0;
            if (!row_done) begin
               row_in      = row_ff + IDX_W'(1);
               row_line_in = next_line;
            end else begin
               row_in      = '0;
               row_line_in = tile_row_base_ff;
               if (!plane_done) begin
                  plane_in = plane_ff + PLANE_W'(1);
               end else begin
                  plane_in = '0;
                  if (!tile_col_last) begin
                     col_origin_in = col_origin_ff + IDX_W'(cfg.tile_width);
                  end else begin
                     col_origin_in = '0;
                     if (!tile_row_last) begin
                        // bottom line of a full tile row, one more line down
                        row_origin_in    = row_origin_ff + IDX_W'(cfg.tile_height);
                        tile_row_base_in = next_line;
                        row_line_in      = next_line;
                     end else begin
                        row_origin_in    = '0;
                        tile_row_base_in = '0;
                        row_line_in      = '0;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff         <= '0;
         col_ff           <= '0;
         row_ff           <= '0;
         col_origin_ff    <= '0;
         row_origin_ff    <= '0;
         row_line_ff      <= '0;
         tile_row_base_ff <= '0;
      end else begin
         plane_ff         <= plane_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         col_origin_ff    <= col_origin_in;
         row_origin_ff    <= row_origin_in;
         row_line_ff      <= row_line_in;
         tile_row_base_ff <= tile_row_base_in;
      end
   end

endmodule

### sim/tile_byte_plane_unshuffle_scatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_byte_plane_unshuffle_scatter_tb
// drives plane-major tile bytes through several image geometries, predicts
// each byte address and the tile and image end markers, and checks every
// result in order while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tile_byte_plane_unshuffle_scatter_tb;
   import tbpus_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int MAX_DIM      = 16384;
   localparam int RANDOM_ITEMS = 1900;
   localparam int MAX_REPORTS  = 10;
   localparam int TIMEOUT_NS   = 4_000_000;

   // indexes past the register map, writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic [ADDR_W-1:0] byte_address;
      logic [BYTE_W-1:0] write_byte;
      logic              tile_last;
      logic              image_last;
   } scatter_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // local drive registers, tied to the channels below
   logic                  req_valid = 1'b0;
   logic [BYTE_W-1:0]     req_data  = '0;
   logic                  rsp_ready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_data  = '0;

   tbpus_req_if req_bus ();
   tbpus_rsp_if rsp_bus ();
   tbpus_csr_if csr_bus ();

   assign req_bus.valid     = req_valid;
   assign req_bus.data_byte = req_data;
   assign rsp_bus.ready     = rsp_ready;
   assign csr_bus.valid     = csr_valid;
   assign csr_bus.index     = csr_index;
   assign csr_bus.data      = csr_data;

   tile_byte_plane_unshuffle_scatter #(
      .MAX_IMAGE_DIM(MAX_DIM)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor: register copies and scan counters
   // ---------------------------------------------------------------------
   bit [CFG_DATA_W-1:0] cfg_image_w = 15'd1;
   bit [CFG_DATA_W-1:0] cfg_image_h = 15'd1;
   bit [CFG_DATA_W-1:0] cfg_tile_w  = 15'd1;
   bit [CFG_DATA_W-1:0] cfg_tile_h  = 15'd1;
   bit [SIZE_W-1:0]     cfg_size_code = '0;
   bit                  cfg_reverse   = 1'b0;

   bit [PLANE_W-1:0] plane  = '0;   // byte plane within the tile
   bit [13:0]        pix_col = '0;  // pixel column inside the tile
   bit [13:0]        pix_row = '0;  // pixel row inside the tile
   bit [13:0]        tile_x  = '0;
   bit [13:0]        tile_y  = '0;
   bit [27:0]        row_base = '0; // pixel index of the current line start

   scatter_write_type expected_writes[$];
   bit [BYTE_W-1:0]   pending_bytes[$];
   int unsigned       failures = 0;

   // stimulus controls
   bit req_idling = 1'b1;
   bit rsp_idling = 1'b1;

   // handshakes seen at the last rising edge
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit csr_taken = 1'b0;

   int unsigned req_gap_left   = 0;
   int unsigned rsp_stall_left = 0;

   function automatic int unsigned clamp_dim(input bit [CFG_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
   endfunction

   // extent of tile number tidx along one axis, clipped at the image edge
   function automatic int unsigned clipped_extent(input int unsigned dim,
                                                  input int unsigned tsz,
                                                  input int unsigned tidx);
      longint unsigned origin;
      origin = 64'(tidx) * tsz;
      if (origin >= dim) return 1;
      if (dim - origin < tsz) return 32'(dim - origin);
      return tsz;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input bit [CFG_DATA_W-1:0] value);
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_image_w   = value;
         CSR_IMAGE_HEIGHT: cfg_image_h   = value;
         CSR_TILE_WIDTH:   cfg_tile_w    = value;
         CSR_TILE_HEIGHT:  cfg_tile_h    = value;
         CSR_PIXEL_SIZE:   cfg_size_code = value[SIZE_W-1:0];
         CSR_REVERSE:      cfg_reverse   = value[0];
         default:          return;
      endcase
      // any mapped write restarts the stream at the first tile
      plane    = '0;
      pix_col  = '0;
      pix_row  = '0;
      tile_x   = '0;
      tile_y   = '0;
      row_base = '0;
   endfunction

   function automatic scatter_write_type predict_write(input bit [BYTE_W-1:0] data);
      int unsigned       w, h, tw, th, size, ntx, nty, cw, ch, place;
      longint unsigned   addr;
      scatter_write_type r;
      w  = clamp_dim(cfg_image_w);
      h  = clamp_dim(cfg_image_h);
      tw = clamp_dim(cfg_tile_w);
      th = clamp_dim(cfg_tile_h);
      if (tw > w) tw = w;
      if (th > h) th = h;
      size = 1 << cfg_size_code;
      ntx  = (w + tw - 1) / tw;
      nty  = (h + th - 1) / th;
      cw   = clipped_extent(w, tw, tile_x);
      ch   = clipped_extent(h, th, tile_y);

      place = cfg_reverse ? size - 1 - 32'(plane) : 32'(plane);
      place = place & (size - 1);
      addr  = 64'(size) * (64'(row_base) + pix_col) + place;

      r.byte_address = addr[ADDR_W-1:0];
      r.write_byte   = data;
      r.tile_last    = (32'(plane) + 1 >= size) && (32'(pix_row) + 1 >= ch) &&
                       (32'(pix_col) + 1 >= cw);
      r.image_last   = r.tile_last && (32'(tile_x) + 1 >= ntx) &&
                       (32'(tile_y) + 1 >= nty);

      // column, row, plane, then tile counters with carry
      if (32'(pix_col) + 1 < cw) begin
         pix_col = pix_col + 1'b1;
      end else begin
         pix_col = '0;
         if (32'(pix_row) + 1 < ch) begin
            pix_row = pix_row + 1'b1;
         end else begin
            pix_row = '0;
            if (32'(plane) + 1 < size) begin
               plane = plane + 1'b1;
            end else begin
               plane = '0;
               if (32'(tile_x) + 1 < ntx) begin
                  tile_x = tile_x + 1'b1;
               end else begin
                  tile_x = '0;
                  // past the last tile a new image begins
                  if (32'(tile_y) + 1 < nty) tile_y = tile_y + 1'b1;
                  else tile_y = '0;
               end
            end
         end
      end
      row_base = 28'((64'(tile_y) * th + pix_row) * w + 64'(tile_x) * tw);
      return r;
   endfunction

   function automatic string describe_write(input scatter_write_type t);
      return $sformatf("addr=%h byte=%h tile_last=%b image_last=%b",
                       t.byte_address, t.write_byte, t.tile_last, t.image_last);
   endfunction

   function automatic void log_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endfunction

   function automatic int unsigned draw_wait(input bit enabled);
      return enabled ? $urandom_range(0, 19) : 0;
   endfunction

   // ---------------------------------------------------------------------
   // monitor: register writes, accepted bytes and result checks
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      scatter_write_type got, want;
      req_taken <= !reset && req_valid && req_bus.ready;
      rsp_taken <= !reset && rsp_bus.valid && rsp_ready;
      csr_taken <= !reset && csr_valid && csr_bus.ready;
      if (!reset) begin
         if (csr_valid && csr_bus.ready) apply_register(csr_index, csr_data);
         // predict first, so a result in the same edge finds its entry
         if (req_valid && req_bus.ready) expected_writes.push_back(predict_write(req_data));
         if (rsp_bus.valid && rsp_ready) begin
            got = '{byte_address: rsp_bus.byte_address, write_byte: rsp_bus.write_byte,
                    tile_last: rsp_bus.tile_last, image_last: rsp_bus.image_last};
            if (expected_writes.size() == 0) begin
               log_failure({"result with nothing expected: ", describe_write(got)});
            end else begin
               want = expected_writes.pop_front();
               if (got !== want)
                  log_failure({"mismatch, expected ", describe_write(want),
                               " got ", describe_write(got)});
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // byte driver: random gap before each item, fed from pending_bytes
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      int unsigned gap;
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left <= 0;
      end else if (!(req_valid && !req_taken)) begin
         // slot is free: either nothing shown or the item was just taken
         gap = req_valid ? draw_wait(req_idling) : req_gap_left;
         if (gap > 0) begin
            req_valid    <= 1'b0;
            req_gap_left <= gap - 1;
         end else if (pending_bytes.size() != 0) begin
            req_data     <= pending_bytes.pop_front();
            req_valid    <= 1'b1;
            req_gap_left <= 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: ready drops for a random stall after each item
   always @(negedge clock) begin
      int unsigned stall;
      if (reset) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         stall = rsp_taken ? draw_wait(rsp_idling)
                           : (rsp_stall_left > 0 ? rsp_stall_left - 1 : 0);
         rsp_stall_left <= stall;
         rsp_ready      <= (stall == 0);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus sequence
   // ---------------------------------------------------------------------
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input bit [CFG_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   // writes the registers selected by mask, in map order
   task automatic program_geometry(input bit [CFG_DATA_W-1:0] values [6],
                                   input bit [5:0] mask);
      csr_index_type r;
      r = r.first();
      do begin
         if (mask[r]) write_register(r, values[r]);
         r = r.next();
      end while (r != r.first());
   endtask

   // polled at the rising edge, where the driver never changes anything
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_writes.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic feed_random(input int unsigned count);
      repeat (count) pending_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
   endtask

   function automatic bit [CFG_DATA_W-1:0] pick_dim(input bit wide);
      if (wide) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CFG_DATA_W'(MAX_DIM);
            2:       return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 32767));
            default: return CFG_DATA_W'($urandom_range(1, MAX_DIM));
         endcase
      end
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2:    return CFG_DATA_W'($urandom_range(7, 20));
         default: return CFG_DATA_W'($urandom_range(1, 6));
      endcase
   endfunction

   initial begin
      bit [CFG_DATA_W-1:0] geom [6];
      int unsigned         sent, phase, count, mode;
      bit                  wide;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry: one byte pixel, 1x1 image, every byte ends the image
      pending_bytes = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
      wait_idle();

      // 3x1 image in 2x1 tiles: clipped edge tile, reversed two byte pixels,
      // and the stream runs past the image end into the next image
      program_geometry('{15'd3, 15'd1, 15'd2, 15'd1, 15'd1, 15'd1}, 6'h3F);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      feed_random(8);
      wait_idle();

      // a write outside the map mid-image must not restart the stream
      write_register(CSR_UNMAPPED_LO, 15'h7FFF);
      feed_random(3);
      wait_idle();

      // zero dimensions act as one, a tile wider than the image is clipped
      program_geometry('{15'd0, 15'd2, 15'h7FFF, 15'd0, 15'd2, 15'd0}, 6'h3F);
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      feed_random(8);
      wait_idle();

      // largest geometry, dimensions above the maximum clamp to it
      program_geometry('{15'h7FFF, 15'd16384, 15'd16384, 15'd1, 15'h7FFF, 15'h7FFF},
                       6'h3F);
      feed_random(4);
      wait_idle();

      // random geometries, mostly small so tiles and images complete often
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         wide = (phase % 5 == 4);
         geom[CSR_IMAGE_WIDTH]  = pick_dim(wide);
         geom[CSR_IMAGE_HEIGHT] = pick_dim(wide);
         geom[CSR_TILE_WIDTH]   = pick_dim($urandom_range(0, 3) == 0);
         geom[CSR_TILE_HEIGHT]  = pick_dim($urandom_range(0, 3) == 0);
         geom[CSR_PIXEL_SIZE]   = CFG_DATA_W'($urandom_range(0, 32767));
         geom[CSR_REVERSE]      = CFG_DATA_W'($urandom_range(0, 32767));
         // some phases rewrite only part of the map, or nothing at all
         program_geometry(geom, (phase % 3 == 0) ? 6'h3F : 6'($urandom));

         // no idling on either side in about a quarter of the phases
         mode       = $urandom_range(0, 3);
         req_idling = mode[0];
         rsp_idling = mode[1];

         count = $urandom_range(30, 180);
         if ($urandom_range(0, 3) == 0) begin
            feed_random(count / 2);
            wait_idle();
            write_register($urandom_range(0, 1) ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO,
                           CFG_DATA_W'($urandom_range(0, 32767)));
            feed_random(count - count / 2);
         end else begin
            feed_random(count);
         end
         wait_idle();
         sent  += count;
         phase++;
      end

      // results are registered, so wait out any stray result before the verdict
      repeat (4) @(negedge clock);
      if (failures == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #(TIMEOUT_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tbpus_pkg.sv
hw/rtl/tbpus_if.sv
hw/rtl/tbpus_cfg.sv
hw/rtl/tbpus_addr_gen.sv
hw/rtl/tile_byte_plane_unshuffle_scatter.sv
sim/tile_byte_plane_unshuffle_scatter_tb.sv
